[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tone channel RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while the reset is released.
`define STC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Checked at every clock edge, during reset too.
`define STC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define STC_ASSERT(lbl, clk, rstn, prop)
`define STC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hw/rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg
// Types, constants and the note period table of the square tone channel.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  // Number of notes that a play transaction may select.
  localparam int NoteCount = 48;
  // Entries actually stored in the period table.
  localparam int TableSize = 48;

  // The length counter steps when the low bits of the prescaler are zero.
  localparam logic [7:0] LengthMask = 8'h3F;

  typedef enum logic {
    FuncTick = 1'b0,
    FuncPlay = 1'b1
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [5:0]       note;
    logic [7:0]       volume;
    logic [7:0]       duration;
    logic signed [7:0] env_step;
    logic signed [7:0] sweep_step;
  } item_t;

  // Period in ticks for each note: 15000 / frequency, truncated, from the
  // lowest C upward in semitones.
  localparam logic [7:0] NotePeriods [TableSize] = '{
    8'd229, 8'd216, 8'd204, 8'd192, 8'd182, 8'd171, 8'd162, 8'd153,
    8'd144, 8'd136, 8'd128, 8'd121, 8'd114, 8'd108, 8'd102, 8'd96,
    8'd91,  8'd85,  8'd81,  8'd76,  8'd72,  8'd68,  8'd64,  8'd60,
    8'd57,  8'd54,  8'd51,  8'd48,  8'd45,  8'd42,  8'd40,  8'd38,
    8'd36,  8'd34,  8'd32,  8'd30,  8'd28,  8'd27,  8'd25,  8'd24,
    8'd22,  8'd21,  8'd20,  8'd19,  8'd18,  8'd17,  8'd16,  8'd15
  };

  // Notes outside the table give period zero, which keeps the tone silent.
  function automatic logic [7:0] note_period(input logic [5:0] idx);
    logic [7:0] result;
    if ((int'(idx) < NoteCount) && (int'(idx) < TableSize)) begin
      result = NotePeriods[idx];
    end else begin
      result = 8'd0;
    end
    return result;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/stc_in_stage.sv]
// ----------------------------------------------------------------------------
// stc_in_stage
// Input register that holds one accepted transaction until it is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_in_stage
  import stc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // A new transaction may enter when the register is empty or drains now.
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[hw/rtl/stc_voice.sv]
// ----------------------------------------------------------------------------
// stc_voice
// Channel state and the tick and play update.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_voice
  import stc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  output logic [7:0] level_o
);

  logic [7:0] phase_q, phase_d;
  logic [7:0] period_q, period_d;
  logic [7:0] level_now_q, level_now_d;
  logic [7:0] remaining_q, remaining_d;
  logic [7:0] env_now_q, env_now_d;
  logic [7:0] sweep_now_q, sweep_now_d;
  logic [7:0] prescaler_q, prescaler_d;

  logic [7:0] phase_inc;
  logic [7:0] phase_tick;
  logic [7:0] presc_tick;
  logic [7:0] remaining_tick;

  // Tick datapath, evaluated every cycle and used only on a tick.
  always_comb begin
    phase_inc  = phase_q + 8'd1;
    phase_tick = (phase_inc > period_q) ? 8'd0 : phase_inc;
    level_o    = ((phase_tick > (period_q >> 1)) && (remaining_q != 8'd0))
                 ? level_now_q : 8'd0;
    presc_tick = prescaler_q - 8'd1;
    remaining_tick = remaining_q;
    if (((presc_tick & LengthMask) == 8'd0) && (remaining_q != 8'd0)) begin
      remaining_tick = remaining_q - 8'd1;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    period_d    = period_q;
    level_now_d = level_now_q;
    remaining_d = remaining_q;
    env_now_d   = env_now_q;
    sweep_now_d = sweep_now_q;
    prescaler_d = prescaler_q;
    if (step_i) begin
      case (item_i.func)
        FuncPlay: begin
          period_d    = note_period(item_i.note);
          level_now_d = item_i.volume;
          remaining_d = item_i.duration;
          env_now_d   = unsigned'(item_i.env_step);
          sweep_now_d = unsigned'(item_i.sweep_step);
        end
        default: begin
          phase_d     = phase_tick;
          prescaler_d = presc_tick;
          remaining_d = remaining_tick;
          if (presc_tick == 8'd0) begin
            if (remaining_tick != 8'd0) begin
              level_now_d = level_now_q + env_now_q;
            end
            period_d = period_q + sweep_now_q;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 8'd0;
      period_q    <= 8'd0;
      level_now_q <= 8'd0;
      remaining_q <= 8'd0;
      env_now_q   <= 8'd0;
      sweep_now_q <= 8'd0;
      prescaler_q <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      period_q    <= period_d;
      level_now_q <= level_now_d;
      remaining_q <= remaining_d;
      env_now_q   <= env_now_d;
      sweep_now_q <= sweep_now_d;
      prescaler_q <= prescaler_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/square_tone_channel_core.sv]
// ----------------------------------------------------------------------------
// square_tone_channel_core
// One-voice square-wave tone channel with length counter, envelope and sweep.
// ----------------------------------------------------------------------------
// Path: a tick transaction accepted into the input register moves into the
//   result register, which shows its level on the output, as soon as the
//   result register is free.
// Throughput: one transaction per cycle, ticks and plays alike, while the result
//   register is free or drained; channel state is updated from the input register.
// Reset: rst_ni clears all channel state and empties the input register and
//   the result register at once; the block accepts transactions right after
//   release.
`default_nettype none
`include "assert_macros.svh"

module square_tone_channel_core
  import stc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              func_i,
  input  wire logic [5:0]        note_i,
  input  wire logic [7:0]        volume_i,
  input  wire logic [7:0]        duration_i,
  input  wire logic signed [7:0] env_step_i,
  input  wire logic signed [7:0] sweep_step_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             level_o
);

  item_t      in_item;
  item_t      stage_item;
  logic       stage_valid;
  logic       advance;
  logic       tick_done;
  logic [7:0] level_calc;

  logic       out_valid_q, out_valid_d;
  logic [7:0] level_q;

  // Pack the incoming fields into one transaction record.
  always_comb begin
    in_item.func       = func_e'(func_i);
    in_item.note       = note_i;
    in_item.volume     = volume_i;
    in_item.duration   = duration_i;
    in_item.env_step   = env_step_i;
    in_item.sweep_step = sweep_step_i;
  end

  // The input register decouples the input handshake from the state update,
  // so a new transaction can be taken while a result waits downstream.
  stc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .take_i  (advance),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  // A play never produces a result, so it may always proceed. A tick needs
  // the result register to be empty or emptied in this same cycle.
  assign advance = stage_valid &&
                   ((stage_item.func == FuncPlay) || !out_valid_q || out_ready_i);
  assign tick_done = advance && (stage_item.func == FuncTick);

  // All channel state lives here and changes once per processed transaction.
  stc_voice u_voice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (stage_item),
    .level_o (level_calc)
  );

  // Result register: filled by a tick, drained by the output handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (tick_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_done) begin
      level_q <= level_calc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

  // Every processed tick leaves a result behind.
  `STC_ASSERT(a_tick_gives_result, clk_i, rst_ni, tick_done |=> out_valid_o)
  // A play leaves the result register as the output handshake left it.
  `STC_ASSERT(a_play_no_result, clk_i, rst_ni,
    (advance && !tick_done) |=> (out_valid_o == $past(out_valid_o && !out_ready_i)))
  // A stalled input means a transaction is waiting in the input register.
  `STC_ASSERT(a_stall_has_item, clk_i, rst_ni, !in_ready_o |-> stage_valid)
  // A tick never overwrites a result that is not being taken.
  `STC_ASSERT(a_no_overwrite, clk_i, rst_ni, tick_done |-> (!out_valid_q || out_ready_i))
  // Reset empties the result register.
  `STC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o)

endmodule

`default_nettype wire
